// ===== rtl/core/cpualu_pkg.sv =====
`timescale 1ns / 1ps

package cpualu_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned ByteWidth = 8;

  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  typedef enum logic [5:0] {
    OP_ADD   = 6'd0,
    OP_ADC   = 6'd1,
    OP_SUB   = 6'd2,
    OP_SBC   = 6'd3,
    OP_CP    = 6'd4,
    OP_AND   = 6'd5,
    OP_OR    = 6'd6,
    OP_XOR   = 6'd7,
    OP_INC   = 6'd8,
    OP_DEC   = 6'd9,
    OP_DAA   = 6'd10,
    OP_CPL   = 6'd11,
    OP_CCF   = 6'd12,
    OP_SCF   = 6'd13,
    OP_RLC   = 6'd14,
    OP_RL    = 6'd15,
    OP_RRC   = 6'd16,
    OP_RR    = 6'd17,
    OP_RLCA  = 6'd18,
    OP_RLA   = 6'd19,
    OP_RRCA  = 6'd20,
    OP_RRA   = 6'd21,
    OP_SLA   = 6'd22,
    OP_SRA   = 6'd23,
    OP_SRL   = 6'd24,
    OP_SWAP  = 6'd25,
    OP_BIT   = 6'd26,
    OP_SET   = 6'd27,
    OP_RES   = 6'd28,
    OP_ADD16 = 6'd29,
    OP_ADDSP = 6'd30,
    OP_INC16 = 6'd31,
    OP_DEC16 = 6'd32
  } alu_op_t;

  typedef struct packed {
    alu_op_t               operation;
    logic [DataWidth-1:0]  operand_a;
    logic [DataWidth-1:0]  operand_b;
    logic [2:0]            bit_index;
    logic                  zero_in;
    logic                  subtract_in;
    logic                  halfcarry_in;
    logic                  carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [DataWidth-1:0]  result;
    logic                  writes_result;
    logic                  zero_out;
    logic                  subtract_out;
    logic                  halfcarry_out;
    logic                  carry_out;
  } alu_rsp_t;

endpackage

// ===== rtl/core/cpu_alu_with_flags_unit.sv =====
`timescale 1ns / 1ps

// SM83-style ALU with flags. A command transfers when start is high and busy
// is low; busy stays low, so one command can be issued every clock. Each
// command yields exactly one result, which passes the input register and then
// the result register: done pulses for one cycle with rsp valid in that cycle.
// The receiver cannot stall, so rsp must be captured when done is high. The
// ALU between those registers is a single combinational pass.
module cpu_alu_with_flags_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cpualu_pkg::alu_req_t req,
  output logic                 done,
  output cpualu_pkg::alu_rsp_t rsp
);

  logic                 req_valid;
  cpualu_pkg::alu_req_t req_q;
  cpualu_pkg::alu_rsp_t rsp_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      req_valid <= start && !busy;
      done      <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (req_valid) begin
      rsp <= rsp_next;
    end
  end

  cpualu_exec u_exec (
    .req (req_q),
    .rsp (rsp_next)
  );

endmodule

// ===== rtl/core/cpualu_exec.sv =====
`timescale 1ns / 1ps

module cpualu_exec (
  input  cpualu_pkg::alu_req_t req,
  output cpualu_pkg::alu_rsp_t rsp
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        arith_cin;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_val;
  logic [7:0]  bit_mask;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [15:0] sp_ext;
  logic [15:0] r;
  logic        wr;
  logic        setz;
  logic        z;
  logic        n;
  logic        h;
  logic        c;

  assign a8 = req.operand_a[7:0];
  assign b8 = req.operand_b[7:0];

  always_comb begin
    arith_cin = 1'b0;
    if (req.operation == cpualu_pkg::OP_ADC || req.operation == cpualu_pkg::OP_SBC) begin
      arith_cin = req.carry_in;
    end
  end

  assign add9 = {1'b0, a8} + {1'b0, b8} + {8'h00, arith_cin};
  assign addh = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, arith_cin};
  assign sub9 = {1'b0, a8} - {1'b0, b8} - {8'h00, arith_cin};
  assign subh = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, arith_cin};

  assign daa_hi = req.carry_in || (a8 > cpualu_pkg::DAA_HI_LIMIT);
  assign daa_lo = req.halfcarry_in || (a8[3:0] > cpualu_pkg::DAA_LO_LIMIT);

  always_comb begin
    if (!req.subtract_in) begin
      daa_val = a8 + (daa_hi ? cpualu_pkg::DAA_HI_ADJ : 8'h00)
                   + (daa_lo ? cpualu_pkg::DAA_LO_ADJ : 8'h00);
    end else begin
      daa_val = a8 - (req.carry_in ? cpualu_pkg::DAA_HI_ADJ : 8'h00)
                   - (req.halfcarry_in ? cpualu_pkg::DAA_LO_ADJ : 8'h00);
    end
  end

  assign bit_mask = 8'h01 << req.bit_index;
  assign add17    = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign add13    = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
  assign sp_ext   = {{8{b8[7]}}, b8};

  always_comb begin
    r    = {8'h00, a8};
    wr   = 1'b1;
    setz = 1'b1;
    z    = req.zero_in;
    n    = req.subtract_in;
    h    = req.halfcarry_in;
    c    = req.carry_in;
    case (req.operation)
      cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
        r = {8'h00, add9[7:0]};
        n = 1'b0;
        h = addh[4];
        c = add9[8];
      end
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP: begin
        r  = {8'h00, sub9[7:0]};
        n  = 1'b1;
        h  = subh[4];
        c  = sub9[8];
        wr = (req.operation != cpualu_pkg::OP_CP);
      end
      cpualu_pkg::OP_AND: begin
        r = {8'h00, a8 & b8};
        n = 1'b0;
        h = 1'b1;
        c = 1'b0;
      end
      cpualu_pkg::OP_OR: begin
        r = {8'h00, a8 | b8};
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      cpualu_pkg::OP_XOR: begin
        r = {8'h00, a8 ^ b8};
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      cpualu_pkg::OP_INC: begin
        r = {8'h00, a8 + 8'h01};
        n = 1'b0;
        h = (a8[3:0] == 4'hF);
      end
      cpualu_pkg::OP_DEC: begin
        r = {8'h00, a8 - 8'h01};
        n = 1'b1;
        h = (a8[3:0] == 4'h0);
      end
      cpualu_pkg::OP_DAA: begin
        r = {8'h00, daa_val};
        h = 1'b0;
        if (!req.subtract_in && daa_hi) begin
          c = 1'b1;
        end
      end
      cpualu_pkg::OP_CPL: begin
        r    = {8'h00, ~a8};
        n    = 1'b1;
        h    = 1'b1;
        setz = 1'b0;
      end
      cpualu_pkg::OP_CCF: begin
        c    = ~req.carry_in;
        n    = 1'b0;
        h    = 1'b0;
        wr   = 1'b0;
        setz = 1'b0;
      end
      cpualu_pkg::OP_SCF: begin
        c    = 1'b1;
        n    = 1'b0;
        h    = 1'b0;
        wr   = 1'b0;
        setz = 1'b0;
      end
      cpualu_pkg::OP_RLC, cpualu_pkg::OP_RLCA: begin
        r = {8'h00, a8[6:0], a8[7]};
        c = a8[7];
        n = 1'b0;
        h = 1'b0;
      end
      cpualu_pkg::OP_RL, cpualu_pkg::OP_RLA: begin
        r = {8'h00, a8[6:0], req.carry_in};
        c = a8[7];
        n = 1'b0;
        h = 1'b0;
      end
      cpualu_pkg::OP_RRC, cpualu_pkg::OP_RRCA: begin
        r = {8'h00, a8[0], a8[7:1]};
        c = a8[0];
        n = 1'b0;
        h = 1'b0;
      end
      cpualu_pkg::OP_RR, cpualu_pkg::OP_RRA: begin
        r = {8'h00, req.carry_in, a8[7:1]};
        c = a8[0];
        n = 1'b0;
        h = 1'b0;
      end
      cpualu_pkg::OP_SLA: begin
        r = {8'h00, a8[6:0], 1'b0};
        c = a8[7];
        n = 1'b0;
        h = 1'b0;
      end
      cpualu_pkg::OP_SRA: begin
        r = {8'h00, a8[7], a8[7:1]};
        c = a8[0];
        n = 1'b0;
        h = 1'b0;
      end
      cpualu_pkg::OP_SRL: begin
        r = {8'h00, 1'b0, a8[7:1]};
        c = a8[0];
        n = 1'b0;
        h = 1'b0;
      end
      cpualu_pkg::OP_SWAP: begin
        r = {8'h00, a8[3:0], a8[7:4]};
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      cpualu_pkg::OP_BIT: begin
        z    = ~|(a8 & bit_mask);
        n    = 1'b0;
        h    = 1'b1;
        wr   = 1'b0;
        setz = 1'b0;
      end
      cpualu_pkg::OP_SET: begin
        r    = {8'h00, a8 | bit_mask};
        setz = 1'b0;
      end
      cpualu_pkg::OP_RES: begin
        r    = {8'h00, a8 & ~bit_mask};
        setz = 1'b0;
      end
      cpualu_pkg::OP_ADD16: begin
        r    = add17[15:0];
        h    = add13[12];
        c    = add17[16];
        n    = 1'b0;
        setz = 1'b0;
      end
      cpualu_pkg::OP_ADDSP: begin
        r    = req.operand_a + sp_ext;
        h    = addh[4];
        c    = add9[8];
        z    = 1'b0;
        n    = 1'b0;
        setz = 1'b0;
      end
      cpualu_pkg::OP_INC16: begin
        r    = req.operand_a + 16'h0001;
        setz = 1'b0;
      end
      cpualu_pkg::OP_DEC16: begin
        r    = req.operand_a - 16'h0001;
        setz = 1'b0;
      end
      default: begin
        r    = req.operand_a;
        wr   = 1'b0;
        setz = 1'b0;
      end
    endcase
    if (setz) begin
      z = (r == 16'h0000);
    end
    if (req.operation inside {cpualu_pkg::OP_RLCA, cpualu_pkg::OP_RLA,
                              cpualu_pkg::OP_RRCA, cpualu_pkg::OP_RRA}) begin
      z = 1'b0;
    end
  end

  assign rsp.result        = r;
  assign rsp.writes_result = wr;
  assign rsp.zero_out      = z;
  assign rsp.subtract_out  = n;
  assign rsp.halfcarry_out = h;
  assign rsp.carry_out     = c;

endmodule

// ===== rtl/core/cpualu_checker.sv =====
`timescale 1ns / 1ps

module cpualu_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input cpualu_pkg::alu_req_t req,
  input logic                 done,
  input cpualu_pkg::alu_rsp_t rsp
);

  // every transfer yields a result once it has passed the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result missing after command transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##2 !done)
    else $error("result without command transfer");

  a_no_write: assert property (@(posedge clk) disable iff (rst)
    done && ($past(req.operation, 2) == cpualu_pkg::OP_CP ||
             $past(req.operation, 2) == cpualu_pkg::OP_BIT ||
             $past(req.operation, 2) == cpualu_pkg::OP_CCF ||
             $past(req.operation, 2) == cpualu_pkg::OP_SCF) |-> !rsp.writes_result)
    else $error("writeback on compare or flag-only op");

  a_addsp_flags: assert property (@(posedge clk) disable iff (rst)
    done && $past(req.operation, 2) == cpualu_pkg::OP_ADDSP
      |-> !rsp.zero_out && !rsp.subtract_out)
    else $error("stack add must clear zero and subtract");

  a_flags_kept: assert property (@(posedge clk) disable iff (rst)
    done && ($past(req.operation, 2) == cpualu_pkg::OP_SET ||
             $past(req.operation, 2) == cpualu_pkg::OP_RES ||
             $past(req.operation, 2) == cpualu_pkg::OP_INC16 ||
             $past(req.operation, 2) == cpualu_pkg::OP_DEC16)
      |-> rsp.zero_out == $past(req.zero_in, 2) &&
          rsp.subtract_out == $past(req.subtract_in, 2) &&
          rsp.halfcarry_out == $past(req.halfcarry_in, 2) &&
          rsp.carry_out == $past(req.carry_in, 2))
    else $error("flags changed on flag-preserving op");

endmodule

bind cpu_alu_with_flags_unit cpualu_checker u_cpualu_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
